// File: hdl/prq_pkg.sv
// Shared types and codes for the priority ready queue.
package prq_pkg;

	localparam int PRIO_BITS  = 16;
	localparam int STATE_BITS = 2;
	localparam int IN_BITS    = 32;
	localparam int OUT_BITS   = 40;

	localparam logic [2:0] MODE_INSERT = 3'd0;
	localparam logic [2:0] MODE_APPEND = 3'd1;
	localparam logic [2:0] MODE_REMOVE = 3'd2;
	localparam logic [2:0] MODE_SET    = 3'd3;
	localparam logic [2:0] MODE_LOOKUP = 3'd4;

	localparam logic [1:0] ST_BLOCKED = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_DEAD    = 2'd2;
	localparam logic [1:0] ST_BAD     = 2'd3;

	localparam logic [1:0] RES_OK        = 2'd0;
	localparam logic [1:0] RES_NOT_FOUND = 2'd1;
	localparam logic [1:0] RES_FULL      = 2'd2;
	localparam logic [1:0] RES_BAD       = 2'd3;

	typedef struct packed {
		logic load;
		logic scan;
		logic shift;
		logic commit;
		logic set_full;
		logic head_rd;
		logic out_load;
	} prq_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       full;
		logic       scan_hit;
		logic       scan_miss;
		logic       shift_done;
		logic       out_free;
	} prq_sts_t;

endpackage

// File: hdl/prq_ctrl.sv
// Operation sequencer for the priority ready queue.
module prq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  prq_pkg::prq_sts_t sts,
	output prq_pkg::prq_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_HEAD   = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if ((sts.op == prq_pkg::MODE_INSERT || sts.op == prq_pkg::MODE_APPEND)
						&& sts.full) begin
					cmd.set_full = 1'b1;
					state_d      = S_HEAD;
				end else if (sts.op == prq_pkg::MODE_APPEND) begin
					cmd.commit = 1'b1;
					state_d    = S_HEAD;
				end else if (sts.op == prq_pkg::MODE_INSERT || sts.op == prq_pkg::MODE_REMOVE
						|| sts.op == prq_pkg::MODE_SET || sts.op == prq_pkg::MODE_LOOKUP) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_HEAD;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_hit || sts.scan_miss) begin
					// insert shifts even on a miss; it then moves nothing
					if (sts.op == prq_pkg::MODE_INSERT
							|| (sts.op == prq_pkg::MODE_REMOVE && sts.scan_hit))
						state_d = S_SHIFT;
					else
						state_d = S_HEAD;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.shift_done) begin
					cmd.commit = 1'b1;
					state_d    = S_HEAD;
				end
			end
			S_HEAD: begin
				cmd.head_rd = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/prq_dpath.sv
// Entry memory, scan and shift pointers, and result register of the queue.
module prq_dpath #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  prq_pkg::prq_cmd_t               cmd,
	output prq_pkg::prq_sts_t               sts,
	input  logic [prq_pkg::IN_BITS-1:0]     s_tdata,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [prq_pkg::OUT_BITS-1:0]    m_tdata
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = ID_BITS + prq_pkg::PRIO_BITS + prq_pkg::STATE_BITS;

	// word: id low, then priority, then state
	logic [EW-1:0] mem [QUEUE_DEPTH];

	logic [2:0]                    op_q;
	logic [ID_BITS-1:0]            id_q;
	logic [prq_pkg::PRIO_BITS-1:0] prio_q;
	logic [1:0]                    nst_q;
	logic [OW-1:0]                 occ_q;
	logic [OW-1:0]                 ptr_q;
	logic [OW-1:0]                 pos_q;
	logic [EW-1:0]                 rd_data_s1;
	logic [AW-1:0]                 rd_addr_s1;
	logic                          scan_vld_s1;
	logic                          mv_s1;
	logic [1:0]                    status_q;
	logic [prq_pkg::PRIO_BITS-1:0] eprio_q;
	logic [1:0]                    estate_q;
	logic                          m_tvalid_q;
	logic [prq_pkg::OUT_BITS-1:0]  m_tdata_q;

	logic [15:0]                   pid_ext;
	logic [1:0]                    in_nst;
	logic [ID_BITS-1:0]            rd_id;
	logic [prq_pkg::PRIO_BITS-1:0] rd_prio;
	logic [1:0]                    rd_state;
	logic                          match;
	logic                          hit;
	logic                          miss;
	logic                          scan_rd;
	logic                          shift_up;
	logic                          shift_rd;
	logic [OW-1:0]                 ptr_dec;
	logic                          rd_en;
	logic [AW-1:0]                 rd_addr;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [EW-1:0]                 wr_data;
	logic [15:0]                   head_ext;
	logic [8:0]                    occ_ext;
	logic                          head_valid;
	logic [7:0]                    head_id;

	assign pid_ext = 16'(s_tdata[10:3]);
	assign in_nst  = (s_tdata[28:27] == prq_pkg::ST_BAD) ? prq_pkg::ST_DEAD : s_tdata[28:27];

	assign rd_id    = rd_data_s1[ID_BITS-1:0];
	assign rd_prio  = rd_data_s1[ID_BITS +: prq_pkg::PRIO_BITS];
	assign rd_state = rd_data_s1[ID_BITS + prq_pkg::PRIO_BITS +: prq_pkg::STATE_BITS];

	always_comb begin
		case (op_q)
			prq_pkg::MODE_INSERT: match = (rd_prio > prio_q);
			prq_pkg::MODE_REMOVE: match = (rd_id == id_q) || (rd_state == prq_pkg::ST_DEAD);
			default:              match = (rd_id == id_q);
		endcase
	end

	assign hit     = cmd.scan && scan_vld_s1 && match;
	assign miss    = cmd.scan && !scan_vld_s1 && (ptr_q >= occ_q);
	assign scan_rd = cmd.scan && !hit && (ptr_q < occ_q);

	assign shift_up = (op_q == prq_pkg::MODE_INSERT);
	assign ptr_dec  = ptr_q - OW'(1);
	assign shift_rd = cmd.shift && (shift_up ? (ptr_q > pos_q) : (ptr_q < occ_q));

	assign rd_en = scan_rd || shift_rd || cmd.head_rd;

	always_comb begin
		if (cmd.head_rd)
			rd_addr = '0;
		else if (cmd.shift && shift_up)
			rd_addr = ptr_dec[AW-1:0];
		else
			rd_addr = ptr_q[AW-1:0];
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q[AW-1:0];
		wr_data = {prq_pkg::ST_READY, prio_q, id_q};
		if (hit && op_q == prq_pkg::MODE_SET) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1;
			wr_data = {nst_q, rd_prio, rd_id};
		end else if (mv_s1) begin
			wr_en   = 1'b1;
			wr_addr = shift_up ? (rd_addr_s1 + AW'(1)) : (rd_addr_s1 - AW'(1));
			wr_data = rd_data_s1;
		end else if (cmd.commit && op_q != prq_pkg::MODE_REMOVE) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			scan_vld_s1 <= 1'b0;
			mv_s1       <= 1'b0;
		end else begin
			scan_vld_s1 <= scan_rd;
			mv_s1       <= shift_rd;
			if (cmd.commit) begin
				if (op_q == prq_pkg::MODE_REMOVE)
					occ_q <= occ_q - OW'(1);
				else
					occ_q <= occ_q + OW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= s_tdata[2:0];
			id_q     <= pid_ext[ID_BITS-1:0];
			prio_q   <= s_tdata[26:11];
			nst_q    <= in_nst;
			ptr_q    <= '0;
			pos_q    <= occ_q;
			status_q <= prq_pkg::RES_OK;
			eprio_q  <= '0;
			estate_q <= '0;
		end else begin
			if (cmd.set_full)
				status_q <= prq_pkg::RES_FULL;
			if (scan_rd)
				ptr_q <= ptr_q + OW'(1);
			if (hit || miss) begin
				// set up the shift pointer for the move that follows
				if (op_q == prq_pkg::MODE_REMOVE)
					ptr_q <= OW'(rd_addr_s1) + OW'(1);
				else
					ptr_q <= occ_q;
			end
			if (hit) begin
				pos_q <= OW'(rd_addr_s1);
				if (op_q == prq_pkg::MODE_LOOKUP) begin
					eprio_q  <= rd_prio;
					estate_q <= rd_state;
				end
			end
			if (miss && op_q != prq_pkg::MODE_INSERT)
				status_q <= prq_pkg::RES_NOT_FOUND;
			if (shift_rd)
				ptr_q <= shift_up ? ptr_dec : (ptr_q + OW'(1));
		end
	end

	// head read lands in rd_data_s1 in S_HEAD, before S_OUT loads the result
	assign head_ext   = 16'(rd_id);
	assign occ_ext    = 9'(occ_q);
	assign head_valid = (occ_q != '0);
	assign head_id    = head_valid ? head_ext[7:0] : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			m_tdata_q <= {6'd0, occ_ext[4:0], head_valid, head_id, estate_q, eprio_q, status_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign sts.op         = op_q;
	assign sts.full       = (occ_q == OW'(QUEUE_DEPTH));
	assign sts.scan_hit   = hit;
	assign sts.scan_miss  = miss;
	assign sts.shift_done = !shift_rd && !mv_s1;
	assign sts.out_free   = !m_tvalid_q || m_tready;

endmodule

// File: hdl/priority_ready_queue_unit.sv
// Top level of the priority ready queue: sequencer plus entry datapath.
// One item at a time: accept, decode, scan to the hit (one entry a cycle; skipped by append,
// full and unused modes), shift of the entries behind it (one a cycle; insert, and remove
// on a hit), head read, result. A new beat is taken once the result is in the output
// register, even if it still waits. Reset empties the queue at once; entry memory is not
// cleared.
module priority_ready_queue_unit #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// mode[2:0], proc_id[10:3], priority_req[26:11], new_state[28:27], zero fill
	input  logic [prq_pkg::IN_BITS-1:0]  s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// status[1:0], entry_priority[17:2], entry_state[19:18], head_id[27:20],
	// head_valid[28], entry_count[33:29], zero fill
	output logic [prq_pkg::OUT_BITS-1:0] m_tdata
);

	prq_pkg::prq_cmd_t cmd;
	prq_pkg::prq_sts_t sts;

	prq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	prq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

// File: hdl/prq_checker.sv
// Port-level checks for the priority ready queue, bound to the top level.
module prq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [prq_pkg::IN_BITS-1:0]  s_tdata,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [prq_pkg::OUT_BITS-1:0] m_tdata
);

	// one item in flight: no beat taken in the cycle after a beat
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != prq_pkg::RES_BAD))
		else $error("undefined status code");

	// lookup fields stay zero unless the status is ok
	a_lookup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] != prq_pkg::RES_OK) |-> (m_tdata[19:2] == '0))
		else $error("lookup fields set on a failed operation");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[28]) |-> (m_tdata[27:20] == '0))
		else $error("head id not zero on an empty queue");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result beat changed");

endmodule

bind priority_ready_queue_unit prq_checker u_prq_checker (.*);

// File: test/tb_priority_ready_queue_unit.sv
// Self-checking testbench for priority_ready_queue_unit: stream stimulus, queue predictor, checker.
`timescale 1ns / 1ps

module tb_priority_ready_queue_unit;

	localparam int QUEUE_DEPTH  = 16;
	localparam int ID_BITS      = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 30;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 412;

	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	localparam logic [15:0] FILL_PRIO [QUEUE_DEPTH] = '{
		16'h8000, 16'h0000, 16'hffff, 16'h8000, 16'h4000, 16'h0000, 16'hffff, 16'h0000,
		16'h7fff, 16'hc000, 16'h0001, 16'hfffe, 16'h5555, 16'haaaa, 16'h8000, 16'h3fff
	};

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] entry_priority;
		logic [1:0]  entry_state;
		logic [7:0]  head_id;
		logic        head_valid;
		logic [4:0]  entry_count;
	} queue_result_t;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [prq_pkg::IN_BITS-1:0]  s_tdata  = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [prq_pkg::OUT_BITS-1:0] m_tdata;

	// predicted queue contents, slot 0 at the front
	logic [7:0]  held_id    [QUEUE_DEPTH];
	logic [15:0] held_prio  [QUEUE_DEPTH];
	logic [1:0]  held_state [QUEUE_DEPTH];
	int          held_count = 0;

	queue_result_t pending_results [$];
	int            mismatch_count = 0;
	int            cycle_count    = 0;
	int            burst_left     = 0;
	int            hold_reqs      = 0;
	int            hold_seen;
	int            hold_left;
	logic [5:0]    stall_phase;
	logic [1:0]    stall_mode;

	priority_ready_queue_unit #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_BITS(ID_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic queue_result_t run_queue_op(input logic [2:0] mode, input logic [7:0] pid,
			input logic [15:0] prio, input logic [1:0] nst);
		queue_result_t r;
		logic [1:0]    st;
		int            pos;
		int            i;
		r = '0;
		r.status = prq_pkg::RES_OK;
		st = (nst == prq_pkg::ST_BAD) ? prq_pkg::ST_DEAD : nst;
		case (mode)
			prq_pkg::MODE_INSERT, prq_pkg::MODE_APPEND: begin
				if (held_count >= QUEUE_DEPTH) begin
					r.status = prq_pkg::RES_FULL;
				end else begin
					pos = held_count;
					if (mode == prq_pkg::MODE_INSERT) begin
						pos = 0;
						while (pos < held_count && held_prio[pos] <= prio)
							pos++;
					end
					for (i = held_count; i > pos; i--) begin
						held_id[i]    = held_id[i-1];
						held_prio[i]  = held_prio[i-1];
						held_state[i] = held_state[i-1];
					end
					held_id[pos]    = pid;
					held_prio[pos]  = prio;
					held_state[pos] = prq_pkg::ST_READY;
					held_count++;
				end
			end
			prq_pkg::MODE_REMOVE: begin
				// first entry that matches the id or is dead, whichever comes first
				pos = -1;
				for (i = 0; i < held_count && pos < 0; i++)
					if (held_id[i] == pid || held_state[i] == prq_pkg::ST_DEAD)
						pos = i;
				if (pos < 0) begin
					r.status = prq_pkg::RES_NOT_FOUND;
				end else begin
					for (i = pos; i + 1 < held_count; i++) begin
						held_id[i]    = held_id[i+1];
						held_prio[i]  = held_prio[i+1];
						held_state[i] = held_state[i+1];
					end
					held_count--;
				end
			end
			prq_pkg::MODE_SET, prq_pkg::MODE_LOOKUP: begin
				pos = -1;
				for (i = 0; i < held_count && pos < 0; i++)
					if (held_id[i] == pid)
						pos = i;
				if (pos < 0) begin
					r.status = prq_pkg::RES_NOT_FOUND;
				end else if (mode == prq_pkg::MODE_SET) begin
					held_state[pos] = st;
				end else begin
					r.entry_priority = held_prio[pos];
					r.entry_state    = held_state[pos];
				end
			end
			default: ;
		endcase
		r.head_id     = (held_count != 0) ? held_id[0] : 8'h00;
		r.head_valid  = (held_count != 0);
		r.entry_count = held_count[4:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got, input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat 0x%0h", m_tdata));
			end else begin
				want = pending_results.pop_front();
				check_field("status", m_tdata[1:0], want.status);
				check_field("entry_priority", m_tdata[17:2], want.entry_priority);
				check_field("entry_state", m_tdata[19:18], want.entry_state);
				check_field("head_id", m_tdata[27:20], want.head_id);
				check_field("head_valid", m_tdata[28], want.head_valid);
				check_field("entry_count", m_tdata[33:29], want.entry_count);
			end
		end
	end

	// receiver: four ready regimes chosen at random, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready    <= 1'b0;
			hold_seen   <= 0;
			hold_left   <= 0;
			stall_phase <= '0;
			stall_mode  <= '0;
		end else if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			stall_phase <= stall_phase + 1'b1;
			if (stall_phase == '0)
				stall_mode <= 2'($urandom_range(0, 3));
			case (stall_mode)
				2'd0:    m_tready <= 1'b1;
				2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
				2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (stall_phase[3:0] < 4'd11);
			endcase
		end
	end

	// one beat; idles after the end of a burst so valid never drops and rises in one step
	task automatic send_item(input logic [2:0] mode, input logic [7:0] pid,
			input logic [15:0] prio, input logic [1:0] nst);
		int gap;
		if (burst_left == 0)
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
		s_tdata  <= {3'b000, nst, prio, pid, mode};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(run_queue_op(mode, pid, prio, nst));
		burst_left--;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic test_empty_queue();
		send_item(prq_pkg::MODE_REMOVE, 8'h00, 16'h0000, prq_pkg::ST_BLOCKED);
		send_item(prq_pkg::MODE_LOOKUP, 8'hff, 16'hffff, prq_pkg::ST_READY);
		send_item(MODE_UNUSED_LO, 8'h00, 16'h0000, prq_pkg::ST_BLOCKED);
		send_item(MODE_UNUSED_HI, 8'hff, 16'hffff, prq_pkg::ST_BAD);
	endtask

	// ties, extremes and two tail appends, then both adding ops on a full queue
	task automatic test_fill_and_full();
		logic [2:0] mode;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			mode = (i == 7 || i == 12) ? prq_pkg::MODE_APPEND : prq_pkg::MODE_INSERT;
			send_item(mode, 8'(i * 17), FILL_PRIO[i], 2'(i));
		end
		send_item(prq_pkg::MODE_INSERT, 8'h12, 16'h2000, prq_pkg::ST_READY);
		send_item(prq_pkg::MODE_APPEND, 8'h34, 16'hffff, prq_pkg::ST_DEAD);
	endtask

	// bad state code saturates to dead; remove then takes the dead entry despite its id
	task automatic test_dead_entry_removal();
		send_item(prq_pkg::MODE_SET, 8'h33, 16'h0000, prq_pkg::ST_BAD);
		send_item(prq_pkg::MODE_LOOKUP, 8'h33, 16'h0000, prq_pkg::ST_BLOCKED);
		send_item(prq_pkg::MODE_REMOVE, 8'h5a, 16'h0000, prq_pkg::ST_BLOCKED);
		send_item(prq_pkg::MODE_LOOKUP, 8'h33, 16'h0000, prq_pkg::ST_BLOCKED);
	endtask

	task automatic random_item(input bit filling);
		int         r;
		logic [2:0] mode;
		logic [7:0] pid;
		logic [15:0] prio;
		r = $urandom_range(0, 99);
		if (r < 3)
			mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
		else if (r < (filling ? 50 : 20))
			mode = ($urandom_range(0, 3) == 0) ? prq_pkg::MODE_APPEND : prq_pkg::MODE_INSERT;
		else if (r < 62)
			mode = prq_pkg::MODE_REMOVE;
		else if (r < 82)
			mode = prq_pkg::MODE_SET;
		else
			mode = prq_pkg::MODE_LOOKUP;
		if (held_count > 0 && $urandom_range(0, 3) != 0)
			pid = held_id[$urandom_range(0, held_count - 1)];
		else
			pid = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 5))
			0:       prio = (held_count > 0) ? held_prio[$urandom_range(0, held_count - 1)] : 16'h0;
			1:       prio = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
			default: prio = 16'($urandom_range(0, 65535));
		endcase
		send_item(mode, pid, prio, 2'($urandom_range(0, 3)));
	endtask

	// receiver holds off while beats keep coming, so the input has to stall
	task automatic test_output_backpressure();
		hold_reqs <= hold_reqs + 1;
		repeat (12) random_item(held_count < QUEUE_DEPTH / 2);
	endtask

	// drifts between filling and draining so both full and empty are reached often
	task automatic test_random_traffic(input int n_items);
		bit filling;
		filling = 1'b0;
		repeat (n_items) begin
			if (held_count == QUEUE_DEPTH)
				filling = 1'b0;
			else if (held_count == 0)
				filling = 1'b1;
			else if ($urandom_range(0, 29) == 0)
				filling = !filling;
			random_item(filling);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_fill_and_full();
		test_dead_entry_removal();
		test_output_backpressure();
		test_random_traffic(RANDOM_ITEMS);
		if (s_tvalid) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: filelist.f
hdl/prq_pkg.sv
hdl/prq_ctrl.sv
hdl/prq_dpath.sv
hdl/priority_ready_queue_unit.sv
hdl/prq_checker.sv
test/tb_priority_ready_queue_unit.sv
